// ===== hdl/kvts_pkg.sv =====
// kvts_pkg: shared types, codes and defaults for the keyframe vector track sampler
`timescale 1ns / 1ps
package kvts_pkg;
    localparam int DATA_W             = 32;
    localparam int MAX_KEYS_DEF       = 64;
    localparam int FRACTION_BITS_DEF  = 16;

    // item kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic [DATA_W-1:0]        stamp;
        logic signed [DATA_W-1:0] value_x;
        logic signed [DATA_W-1:0] value_y;
        logic signed [DATA_W-1:0] value_z;
    } in_word_t;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     overflow;
    } out_word_t;
endpackage

// ===== hdl/kvts_ram.sv =====
// kvts_ram: generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module kvts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/kvts_div_cell.sv =====
// kvts_div_cell: one restoring division step, registered, for the fraction divider chain
`timescale 1ns / 1ps
module kvts_div_cell #(
    parameter int QW = kvts_pkg::FRACTION_BITS_DEF
) (
    input  logic                        aclk,
    input  logic [kvts_pkg::DATA_W-1:0] rem_in,
    input  logic [kvts_pkg::DATA_W-1:0] den_in,
    input  logic [QW-1:0]               quo_in,
    output logic [kvts_pkg::DATA_W-1:0] rem_out,
    output logic [kvts_pkg::DATA_W-1:0] den_out,
    output logic [QW-1:0]               quo_out
);
    logic [kvts_pkg::DATA_W:0] shifted;
    logic                      ge;

    // shift in one bit and try to subtract the divisor
    always_comb begin
        shifted = {rem_in, 1'b0};
        ge      = (shifted >= {1'b0, den_in});
    end

    always_ff @(posedge aclk) begin
        rem_out <= ge ? kvts_pkg::DATA_W'(shifted - {1'b0, den_in})
                      : shifted[kvts_pkg::DATA_W-1:0];
        den_out <= den_in;
        quo_out <= {quo_in[QW-2:0], ge};
    end
endmodule

// ===== hdl/keyframe_vector_track_sampler.sv =====
// keyframe_vector_track_sampler: one result word per input word
// Clear, append and unknown words go from accept straight to the output state.
// Query: time is set by one key ram read per search step, the fetch of the bracketing keys,
// the divider cell chain and one shared multiplier.
// One word is in work at a time; a finished result waits in the output register.
// Reset (aresetn, synchronous) empties the track; key ram contents are not cleared.
`timescale 1ns / 1ps
module keyframe_vector_track_sampler #(
    parameter int MAX_KEYS      = kvts_pkg::MAX_KEYS_DEF,
    parameter int FRACTION_BITS = kvts_pkg::FRACTION_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  kvts_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output kvts_pkg::out_word_t m_word
);
    localparam int DW  = kvts_pkg::DATA_W;
    localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW  = $clog2(MAX_KEYS + 1);
    localparam int FB  = FRACTION_BITS;
    localparam int KW  = 4 * DW;
    localparam int PW  = DW + FB + 3;
    localparam int DCW = $clog2(FB + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SRCH_RD, ST_SRCH_CMP, ST_FETCH_P, ST_FETCH_N, ST_FETCH_END,
        ST_DIV, ST_MUL, ST_ADD, ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           low_reg, high_reg;
    logic [AW-1:0]           mid_reg, fetch_addr_reg, idx_reg;
    logic                    single_reg;
    logic [DW-1:0]           stamp_reg;
    logic [DW-1:0]           p_time_reg;
    logic signed [DW-1:0]    p_val_reg [3];
    logic signed [DW-1:0]    n_val_reg [3];
    logic signed [DW-1:0]    res_val_reg [3];
    logic [DW-1:0]           div_num_reg, div_den_reg;
    logic [DCW-1:0]          div_cnt_reg;
    logic [FB:0]             frac_reg;
    logic [1:0]              comp_reg;
    logic signed [PW-1:0]    prod_reg;
    kvts_pkg::out_word_t     res_reg;
    kvts_pkg::out_word_t     m_word_reg;
    logic                    m_valid_reg;

    logic                    ram_we;
    logic [AW-1:0]           ram_raddr;
    logic [KW-1:0]           ram_wdata, ram_rdata;
    logic [DW-1:0]           rd_time;
    logic signed [DW-1:0]    rd_val [3];
    logic [CW:0]             mid_sum;
    logic [AW-1:0]           mid;
    logic signed [DW:0]      diff;

    logic [DW-1:0]           chain_rem [FB+1];
    logic [DW-1:0]           chain_den [FB+1];
    logic [FB-1:0]           chain_quo [FB+1];

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // key store: time and xyz in one word
    assign ram_we    = s_valid && s_ready && (s_word.kind == kvts_pkg::KIND_APPEND)
                       && (count_reg < CW'(MAX_KEYS));
    assign ram_wdata = {s_word.stamp, s_word.value_x, s_word.value_y, s_word.value_z};
    assign rd_time   = ram_rdata[KW-1 -: DW];
    assign rd_val[0] = ram_rdata[3*DW-1 -: DW];
    assign rd_val[1] = ram_rdata[2*DW-1 -: DW];
    assign rd_val[2] = ram_rdata[DW-1:0];

    kvts_ram #(.WIDTH(KW), .DEPTH(MAX_KEYS)) u_keys (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // search midpoint and read address
    always_comb begin
        mid_sum = {1'b0, low_reg} + {1'b0, high_reg};
        mid     = mid_sum[AW:1];
        case (state_reg)
            ST_SRCH_RD: ram_raddr = mid;
            ST_FETCH_P: ram_raddr = fetch_addr_reg;
            ST_FETCH_N: ram_raddr = idx_reg;
            default:    ram_raddr = mid;
        endcase
    end

    // fraction divider: row of restoring step cells
    assign chain_rem[0] = div_num_reg;
    assign chain_den[0] = div_den_reg;
    assign chain_quo[0] = '0;
    for (genvar g = 0; g < FB; g++) begin : g_div
        kvts_div_cell #(.QW(FB)) u_cell (
            .aclk    (aclk),
            .rem_in  (chain_rem[g]),
            .den_in  (chain_den[g]),
            .quo_in  (chain_quo[g]),
            .rem_out (chain_rem[g+1]),
            .den_out (chain_den[g+1]),
            .quo_out (chain_quo[g+1])
        );
    end

    // component difference for the shared multiplier
    assign diff = {n_val_reg[comp_reg][DW-1], n_val_reg[comp_reg]}
                - {p_val_reg[comp_reg][DW-1], p_val_reg[comp_reg]};

    // sequencer, state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        res_reg   <= '0;
                        stamp_reg <= s_word.stamp;
                        state_reg <= ST_OUT;
                        case (s_word.kind)
                            kvts_pkg::KIND_CLEAR: begin
                                count_reg <= '0;
                            end
                            kvts_pkg::KIND_APPEND: begin
                                if (count_reg < CW'(MAX_KEYS)) begin
                                    count_reg <= count_reg + 1'b1;
                                end else begin
                                    res_reg.overflow <= 1'b1;
                                end
                            end
                            kvts_pkg::KIND_QUERY: begin
                                if (count_reg != '0) begin
                                    low_reg   <= '0;
                                    high_reg  <= count_reg;
                                    state_reg <= ST_SRCH_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SRCH_RD: begin
                    if (low_reg < high_reg) begin
                        mid_reg   <= mid;
                        state_reg <= ST_SRCH_CMP;
                    end else begin
                        state_reg <= ST_FETCH_P;
                        idx_reg   <= low_reg[AW-1:0];
                        if (low_reg == '0) begin
                            single_reg     <= 1'b1;
                            fetch_addr_reg <= '0;
                        end else if (low_reg >= count_reg) begin
                            single_reg     <= 1'b1;
                            fetch_addr_reg <= AW'(count_reg - 1'b1);
                        end else begin
                            single_reg     <= 1'b0;
                            fetch_addr_reg <= AW'(low_reg - 1'b1);
                        end
                    end
                end
                ST_SRCH_CMP: begin
                    if (rd_time <= stamp_reg) begin
                        low_reg <= CW'(mid_reg) + 1'b1;
                    end else begin
                        high_reg <= CW'(mid_reg);
                    end
                    state_reg <= ST_SRCH_RD;
                end
                ST_FETCH_P: begin
                    state_reg <= ST_FETCH_N;
                end
                ST_FETCH_N: begin
                    p_time_reg <= rd_time;
                    for (int c = 0; c < 3; c++) begin
                        p_val_reg[c]   <= rd_val[c];
                        res_val_reg[c] <= rd_val[c];
                    end
                    state_reg <= single_reg ? ST_OUT : ST_FETCH_END;
                    res_reg.found    <= 1'b1;
                    res_reg.out_x    <= rd_val[0];
                    res_reg.out_y    <= rd_val[1];
                    res_reg.out_z    <= rd_val[2];
                    res_reg.overflow <= 1'b0;
                end
                ST_FETCH_END: begin
                    for (int c = 0; c < 3; c++) begin
                        n_val_reg[c] <= rd_val[c];
                    end
                    div_num_reg <= stamp_reg - p_time_reg;
                    div_den_reg <= rd_time - p_time_reg;
                    comp_reg    <= '0;
                    div_cnt_reg <= '0;
                    if (rd_time <= p_time_reg || stamp_reg < p_time_reg) begin
                        frac_reg  <= '0;
                        state_reg <= ST_MUL;
                    end else if ((stamp_reg - p_time_reg) >= (rd_time - p_time_reg)) begin
                        frac_reg  <= {1'b1, {FB{1'b0}}};
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_cnt_reg == DCW'(FB)) begin
                        frac_reg  <= {1'b0, chain_quo[FB]};
                        state_reg <= ST_MUL;
                    end else begin
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= PW'(diff) * PW'($signed({1'b0, frac_reg}));
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    res_val_reg[comp_reg] <= p_val_reg[comp_reg] + prod_reg[FB+DW-1:FB];
                    if (comp_reg == 2'd2) begin
                        state_reg <= ST_OUT;
                    end else begin
                        comp_reg  <= comp_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                    if (comp_reg == 2'd2) begin
                        res_reg.out_x <= res_val_reg[0];
                        res_reg.out_y <= res_val_reg[1];
                        res_reg.out_z <= p_val_reg[2] + prod_reg[FB+DW-1:FB];
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_word_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== tb/testbench.sv =====
// testbench: drives keyframe track words into the sampler and checks every result word
`timescale 1ns / 1ps
module testbench;
    localparam int TRACK_DEPTH = kvts_pkg::MAX_KEYS_DEF;
    localparam int FRAC_BITS   = kvts_pkg::FRACTION_BITS_DEF;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    kvts_pkg::in_word_t  s_word = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    kvts_pkg::out_word_t m_word;

    // stimulus and expected result stores
    kvts_pkg::in_word_t  pending_words[$];
    kvts_pkg::out_word_t expected_samples[$];
    int        failures = 0;
    int        accepted_count = 0;
    bit        word_taken = 1'b0;

    // shadow copy of the track
    logic [31:0]        shadow_time[TRACK_DEPTH];
    logic signed [31:0] shadow_vec[TRACK_DEPTH][3];
    int                 shadow_len = 0;

    keyframe_vector_track_sampler DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    always #4 aclk = ~aclk;

    // sample the track the way the block does and update the shadow track
    function automatic kvts_pkg::out_word_t sample_track(kvts_pkg::in_word_t w);
        kvts_pkg::out_word_t r;
        int lo, hi, mid, idx, k, c;
        longint a, b, f, num, den;
        longint res[3];
        r = '0;
        if (w.kind == kvts_pkg::KIND_CLEAR) begin
            shadow_len = 0;
        end else if (w.kind == kvts_pkg::KIND_APPEND) begin
            if (shadow_len >= TRACK_DEPTH) begin
                r.overflow = 1'b1;
            end else begin
                shadow_time[shadow_len] = w.stamp;
                shadow_vec[shadow_len][0] = w.value_x;
                shadow_vec[shadow_len][1] = w.value_y;
                shadow_vec[shadow_len][2] = w.value_z;
                shadow_len++;
            end
        end else if (w.kind == kvts_pkg::KIND_QUERY && shadow_len > 0) begin
            lo = 0;
            hi = shadow_len;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (shadow_time[mid] <= w.stamp) lo = mid + 1;
                else hi = mid;
            end
            idx = lo;
            if (idx == 0 || idx >= shadow_len) begin
                k = (idx == 0) ? 0 : shadow_len - 1;
                for (c = 0; c < 3; c++) res[c] = shadow_vec[k][c];
            end else begin
                // fraction between the bracketing keys, clamped to [0, one]
                if (shadow_time[idx] <= shadow_time[idx-1] || w.stamp < shadow_time[idx-1]) begin
                    f = 0;
                end else begin
                    num = longint'({32'd0, w.stamp - shadow_time[idx-1]});
                    den = longint'({32'd0, shadow_time[idx] - shadow_time[idx-1]});
                    f = (num >= den) ? (longint'(1) <<< FRAC_BITS) : (num <<< FRAC_BITS) / den;
                end
                for (c = 0; c < 3; c++) begin
                    a = shadow_vec[idx-1][c];
                    b = shadow_vec[idx][c];
                    res[c] = a + (((b - a) * f) >>> FRAC_BITS);
                end
            end
            r.found = 1'b1;
            r.out_x = res[0][31:0];
            r.out_y = res[1][31:0];
            r.out_z = res[2][31:0];
        end
        return r;
    endfunction

    task automatic add_word(logic [1:0] kind, logic [31:0] stamp,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z);
        kvts_pkg::in_word_t w;
        w.kind = kind;
        w.stamp = stamp;
        w.value_x = x;
        w.value_y = y;
        w.value_z = z;
        pending_words.push_back(w);
    endtask

    // idle percentages per phase
    function automatic int sender_idle_pct();
        if (accepted_count < 260) return 17;
        if (accepted_count < 520) return 87;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (accepted_count < 260) return 87;
        if (accepted_count < 520) return 17;
        return 0;
    endfunction

    // driver: new word or idle at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || word_taken) begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    s_word <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            word_taken = 1'b0;
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // monitor: predict on accept, compare on result
    always @(posedge aclk) begin
        kvts_pkg::out_word_t exp_w;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_samples.push_back(sample_track(s_word));
                accepted_count++;
                word_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_word);
                    failures++;
                end else begin
                    exp_w = expected_samples.pop_front();
                    if (m_word.found !== exp_w.found) begin
                        $display("%0t: found expected %0d actual %0d", $time, exp_w.found, m_word.found);
                        failures++;
                    end
                    if (m_word.out_x !== exp_w.out_x) begin
                        $display("%0t: out_x expected %h actual %h", $time, exp_w.out_x, m_word.out_x);
                        failures++;
                    end
                    if (m_word.out_y !== exp_w.out_y) begin
                        $display("%0t: out_y expected %h actual %h", $time, exp_w.out_y, m_word.out_y);
                        failures++;
                    end
                    if (m_word.out_z !== exp_w.out_z) begin
                        $display("%0t: out_z expected %h actual %h", $time, exp_w.out_z, m_word.out_z);
                        failures++;
                    end
                    if (m_word.overflow !== exp_w.overflow) begin
                        $display("%0t: overflow expected %0d actual %0d", $time, exp_w.overflow,
                                 m_word.overflow);
                        failures++;
                    end
                end
            end
        end
    end

    // timeout
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        longint t, first_t, last_t;
        int n, q, i;
        // directed: empty track, unknown kind, extremes, before, between, past, unsorted
        add_word(kvts_pkg::KIND_QUERY, 32'h0001_0000, '1, '1, '1);
        add_word(KIND_UNKNOWN, '1, '1, '1, '1);
        add_word(kvts_pkg::KIND_APPEND, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h0000_0000);
        add_word(kvts_pkg::KIND_APPEND, 32'h0003_0000, 32'h8000_0000, 32'h7fff_ffff,
                 32'hffff_ffff);
        add_word(kvts_pkg::KIND_APPEND, 32'hffff_fffe, 32'h0001_8000, 32'hfffe_8000,
                 32'h0000_0001);
        add_word(kvts_pkg::KIND_QUERY, 32'h0000_0000, 0, 0, 0);
        add_word(kvts_pkg::KIND_QUERY, 32'h0001_0000, 0, 0, 0);
        add_word(kvts_pkg::KIND_QUERY, 32'h0002_0000, 0, 0, 0);
        add_word(kvts_pkg::KIND_QUERY, 32'h0002_ffff, 0, 0, 0);
        add_word(kvts_pkg::KIND_QUERY, 32'h0003_0000, 0, 0, 0);
        add_word(kvts_pkg::KIND_QUERY, 32'h8000_0000, 0, 0, 0);
        add_word(kvts_pkg::KIND_QUERY, 32'hffff_ffff, 0, 0, 0);
        add_word(kvts_pkg::KIND_APPEND, 32'h0002_0000, 32'h1234_5678, 32'hedcb_a988,
                 32'h5555_aaaa);
        add_word(kvts_pkg::KIND_APPEND, 32'h0002_0000, 32'h0000_0010, 32'h0000_0020,
                 32'h0000_0030);
        add_word(kvts_pkg::KIND_QUERY, 32'hffff_fffe, 0, 0, 0);
        add_word(kvts_pkg::KIND_QUERY, 32'h0001_0000, 0, 0, 0);
        add_word(kvts_pkg::KIND_CLEAR, '1, '1, '1, '1);
        add_word(kvts_pkg::KIND_QUERY, 32'h0002_0000, 0, 0, 0);
        add_word(kvts_pkg::KIND_APPEND, 32'h0000_0000, 32'h0000_0100, 32'h0000_0000,
                 32'hffff_ff00);
        add_word(kvts_pkg::KIND_QUERY, 32'h0000_0000, 0, 0, 0);
        add_word(kvts_pkg::KIND_QUERY, 32'hffff_ffff, 0, 0, 0);
        add_word(kvts_pkg::KIND_CLEAR, 0, 0, 0, 0);

        // random: mostly clean tracks with queries, some noise and overfull tracks
        while (pending_words.size() < 740) begin
            if ($urandom_range(0, 9) < 8) begin
                add_word(kvts_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
                n = ($urandom_range(0, 19) == 0) ? TRACK_DEPTH + 2 : $urandom_range(1, 8);
                t = $urandom_range(0, 1 << 20);
                first_t = t;
                for (i = 0; i < n; i++) begin
                    add_word(kvts_pkg::KIND_APPEND, t[31:0], $urandom, $urandom, $urandom);
                    last_t = t;
                    if ($urandom_range(0, 9) == 0) t = t;
                    else if ($urandom_range(0, 9) == 0) t = t + $urandom_range(0, 1 << 30);
                    else t = t + $urandom_range(1, 1 << 22);
                    if (t > 64'hffff_ffff) t = 64'hffff_ffff;
                end
                q = $urandom_range(1, 5);
                for (i = 0; i < q; i++) begin
                    if ($urandom_range(0, 7) == 0)
                        t = $urandom;
                    else
                        t = first_t - 1000 + $urandom_range(0, 1 << 24) % (last_t - first_t + 2001);
                    if (t < 0) t = 0;
                    add_word(kvts_pkg::KIND_QUERY, t[31:0], $urandom, $urandom, $urandom);
                end
            end else begin
                add_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
            end
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        wait (pending_words.size() == 0 && !s_valid && expected_samples.size() == 0);
        repeat (100) @(posedge aclk);
        if (failures == 0 && expected_samples.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
